>>> rtl/core/nte_pkg.sv
// Types and constants shared by the number-to-text emitter.
package nte_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  // The high bit of the operation selects hexadecimal.
  localparam int unsigned OP_HEX_BIT = 1;

  // ASCII characters used in the text.
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_HEX_BASE = 8'h57;  // 'a' - 10
  localparam logic [7:0] CHAR_MINUS    = 8'h2d;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // Decimal radix and the reciprocal used to divide a 32-bit value by ten.
  localparam logic [3:0]  RADIX_DEC   = 4'd10;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Largest digit count kept for one number.
  localparam int unsigned NUM_DIGITS = 11;
  localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);

  // Width of the pad and length counters (the field width is at most 63).
  localparam int unsigned CNT_W = 7;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic [5:0]  min_width;
    logic        zero_pad;
  } nte_req_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } nte_res_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_PAD   = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } nte_state_e;

endpackage

>>> rtl/core/number_to_text_emitter_core.sv
// Number-to-text emitter: formats one integer as padded ASCII, one character per cycle.
//
//   Channel   Direction  Handshake              Payload
//   request   in         start_i when !busy_o    req_i (op, value, min_width, zero_pad)
//   result    out        res_valid_o strobe      res_o (text_char, last_char)
//
// A request first runs the conversion loop (one pass of the
// shared divide-by-radix unit per digit, up to ten for decimal, eight for hex),
// then emits its characters: pads, the sign and the digits.
// Each character appears on res_o in the cycle after it is chosen, for one cycle.
// busy_o is high from acceptance until the last character is chosen.
// Reset clears the sequencer and the result strobe; the receiver cannot stall.
module number_to_text_emitter_core #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  nte_pkg::nte_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output nte_pkg::nte_res_t res_o
);

  localparam int unsigned CW = nte_pkg::CNT_W;
  localparam int unsigned IW = nte_pkg::DIG_IDX_W;

  nte_pkg::nte_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  hex_q, hex_d;
  logic                  neg_q, neg_d;
  logic [7:0]            pad_q, pad_d;
  logic [CW-1:0]         width_q, width_d;
  logic [CW-1:0]         pads_q, pads_d;
  logic [IW-1:0]         ndig_q, ndig_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [3:0]            digits_q [nte_pkg::NUM_DIGITS];

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  // Shared divide-by-radix unit.
  logic [31:0]           mag_ext;
  logic [63:0]           prod;
  logic [31:0]           quot_dec;
  logic [3:0]            rem_dec;
  logic [VALUE_BITS-1:0] quot;
  logic [3:0]            rem;
  logic                  conv_done;

  // Request decode.
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_neg;
  logic [CW-1:0]         in_width;

  // Emission helpers.
  logic [CW-1:0]         text_len;
  logic [3:0]            cur_digit;
  logic [7:0]            digit_char;

  // Divide the magnitude by ten through its reciprocal, or by sixteen with a shift.
  always_comb begin
    mag_ext  = 32'(mag_q);
    prod     = 64'(mag_ext) * 64'(nte_pkg::RECIP_TEN);
    quot_dec = 32'(prod >> nte_pkg::RECIP_SHIFT);
    rem_dec  = 4'(mag_ext - (quot_dec << 3) - (quot_dec << 1));
    if (hex_q) begin
      quot      = mag_q >> 4;
      rem       = mag_q[3:0];
      conv_done = (mag_q >> 4) == '0;
    end else begin
      quot      = VALUE_BITS'(quot_dec);
      rem       = rem_dec;
      conv_done = mag_ext < 32'(nte_pkg::RADIX_DEC);
    end
  end

  // Decode the incoming request: magnitude, sign and saturated width.
  always_comb begin
    in_val = req_i.value[VALUE_BITS-1:0];
    in_neg = (req_i.op == nte_pkg::OP_SDEC) && in_val[VALUE_BITS-1];
    if (in_neg) begin
      in_val = '0 - in_val;
    end
    if (CW'(req_i.min_width) > CW'(MAX_WIDTH)) begin
      in_width = CW'(MAX_WIDTH);
    end else begin
      in_width = CW'(req_i.min_width);
    end
  end

  // Character for the digit being emitted.
  always_comb begin
    cur_digit = digits_q[idx_q];
    if (cur_digit < nte_pkg::RADIX_DEC) begin
      digit_char = nte_pkg::CHAR_ZERO + 8'(cur_digit);
    end else begin
      digit_char = nte_pkg::CHAR_HEX_BASE + 8'(cur_digit);
    end
  end

  assign text_len = CW'(ndig_q) + CW'(1) + CW'(neg_q);

  // Sequencer: convert digits, then emit pads, sign and digits.
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    hex_d       = hex_q;
    neg_d       = neg_q;
    pad_d       = pad_q;
    width_d     = width_q;
    pads_d      = pads_q;
    ndig_d      = ndig_q;
    idx_d       = idx_q;
    out_valid_d = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = 1'b0;

    unique case (state_q)
      nte_pkg::ST_IDLE: begin
        if (start_i) begin
          mag_d   = in_val;
          hex_d   = req_i.op[nte_pkg::OP_HEX_BIT];
          neg_d   = in_neg;
          pad_d   = req_i.zero_pad ? nte_pkg::CHAR_ZERO : nte_pkg::CHAR_SPACE;
          width_d = in_width;
          ndig_d  = '0;
          state_d = nte_pkg::ST_CONV;
        end
      end
      nte_pkg::ST_CONV: begin
        mag_d = quot;
        if (conv_done || (32'(ndig_q) + 32'd1 >= nte_pkg::NUM_DIGITS)) begin
          idx_d = ndig_q;
          if (width_q > text_len) begin
            pads_d  = width_q - text_len;
            state_d = nte_pkg::ST_PAD;
          end else if (neg_q) begin
            state_d = nte_pkg::ST_SIGN;
          end else begin
            state_d = nte_pkg::ST_DIGIT;
          end
        end else begin
          ndig_d = ndig_q + IW'(1);
        end
      end
      nte_pkg::ST_PAD: begin
        out_valid_d = 1'b1;
        out_char_d  = pad_q;
        pads_d      = pads_q - CW'(1);
        if (pads_q == CW'(1)) begin
          state_d = neg_q ? nte_pkg::ST_SIGN : nte_pkg::ST_DIGIT;
        end
      end
      nte_pkg::ST_SIGN: begin
        out_valid_d = 1'b1;
        out_char_d  = nte_pkg::CHAR_MINUS;
        state_d     = nte_pkg::ST_DIGIT;
      end
      nte_pkg::ST_DIGIT: begin
        out_valid_d = 1'b1;
        out_char_d  = digit_char;
        if (idx_q == '0) begin
          out_last_d = 1'b1;
          state_d    = nte_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end
      default: begin
        state_d = nte_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nte_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    hex_q      <= hex_d;
    neg_q      <= neg_d;
    pad_q      <= pad_d;
    width_q    <= width_d;
    pads_q     <= pads_d;
    ndig_q     <= ndig_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Digit buffer, filled least significant digit first.
  always_ff @(posedge clk_i) begin
    if (state_q == nte_pkg::ST_CONV) begin
      digits_q[ndig_q] <= rem;
    end
  end

  assign busy_o          = (state_q != nte_pkg::ST_IDLE);
  assign res_valid_o     = out_valid_q;
  assign res_o.text_char = out_char_q;
  assign res_o.last_char = out_last_q;

endmodule
